// File: hw/rtl/sawlc_pkg.sv
// shared types, geometry constants and address helpers for the set-associative cache
package sawlc_pkg;

    localparam int WAYS      = 4;
    localparam int SETS      = 64;
    localparam int ADDR_BITS = 32;

    localparam int IDX_BITS = $clog2(SETS);
    localparam int TAG_LEN  = (ADDR_BITS - IDX_BITS - 2 > 0) ? (ADDR_BITS - IDX_BITS - 2) : 0;
    localparam int SET_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int TAG_W    = (TAG_LEN > 0) ? TAG_LEN : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W   = WAY_W;

    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [31:0] TAG_MASK  = 32'((64'd1 << TAG_LEN) - 64'd1);

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [31:0] write_data;
        logic [31:0] fill_data;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        hit;
        logic        writeback_valid;
        logic [31:0] writeback_addr;
        logic [31:0] writeback_data;
    } t_out;

    typedef struct packed {
        logic              valid;
        logic              dirty;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  tag;
        logic [31:0]       word;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    typedef struct packed {
        logic             hit;
        logic             evict;
        logic [WAY_W-1:0] victim;
    } t_scan;

    localparam logic KIND_WRITE = 1'b1;

    // set index: the shifted value is always below twice SETS
    function automatic logic [SET_W-1:0] set_of(input logic [31:0] addr);
        logic [31:0] a;
        logic [31:0] s;
        a = addr & ADDR_MASK;
        s = a >> (TAG_LEN + 2);
        if (s >= 32'(SETS)) begin
            s = s - 32'(SETS);
        end
        return s[SET_W-1:0];
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] addr);
        logic [31:0] a;
        a = ((addr & ADDR_MASK) >> 2) & TAG_MASK;
        return a[TAG_W-1:0];
    endfunction

    function automatic logic [31:0] line_addr(input logic [TAG_W-1:0] tag,
                                              input logic [SET_W-1:0] set);
        logic [63:0] v;
        v = ((64'(tag) & 64'(TAG_MASK)) << 2) | (64'(set) << (TAG_LEN + 2));
        return v[31:0];
    endfunction

endpackage

// File: hw/rtl/sawlc_scan.sv
// way-serial compare unit: tag match, first invalid way and least-ranked way
module sawlc_scan import sawlc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_step,
    input  logic [WAY_W-1:0] i_way,
    input  t_way             i_entry,
    input  logic [TAG_W-1:0] i_tag,
    output t_scan            o_scan
);

    logic              r_hit;
    logic [WAY_W-1:0]  r_hit_way;
    logic              r_inv;
    logic [WAY_W-1:0]  r_inv_way;
    logic [WAY_W-1:0]  r_min_way;
    logic [RANK_W-1:0] r_min_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit      <= 1'b0;
            r_hit_way  <= '0;
            r_inv      <= 1'b0;
            r_inv_way  <= '0;
            r_min_way  <= '0;
            r_min_rank <= '0;
        end else if (i_clear) begin
            r_hit <= 1'b0;
            r_inv <= 1'b0;
        end else if (i_step) begin
            if (i_entry.valid && (i_entry.tag == i_tag) && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_way <= i_way;
            end
            if (!i_entry.valid && !r_inv) begin
                r_inv     <= 1'b1;
                r_inv_way <= i_way;
            end
            // strict less-than keeps the lowest way on a tie
            if ((i_way == '0) || (i_entry.rank < r_min_rank)) begin
                r_min_way  <= i_way;
                r_min_rank <= i_entry.rank;
            end
        end
    end

    always_comb begin
        o_scan.hit   = r_hit;
        o_scan.evict = !r_hit && !r_inv;
        if (r_hit) begin
            o_scan.victim = r_hit_way;
        end else if (r_inv) begin
            o_scan.victim = r_inv_way;
        end else begin
            o_scan.victim = r_min_way;
        end
    end

endmodule

// File: hw/rtl/sawlc_update.sv
// builds the new set row (fill, rank update, store) and the transaction result
module sawlc_update import sawlc_pkg::*; (
    input  t_row             i_row,
    input  t_scan            i_scan,
    input  t_in              i_req,
    input  logic [SET_W-1:0] i_set,
    input  logic [TAG_W-1:0] i_tag,
    output t_row             o_row,
    output t_out             o_rsp
);

    t_way              old_way;
    logic [RANK_W-1:0] old_rank;
    logic              wb;

    always_comb begin
        old_way  = i_row[i_scan.victim];
        old_rank = old_way.rank;
        wb       = i_scan.evict && old_way.dirty;
        o_row    = i_row;

        if (!i_scan.hit) begin
            o_row[i_scan.victim].valid = 1'b1;
            o_row[i_scan.victim].dirty = 1'b0;
            o_row[i_scan.victim].tag   = i_tag;
            o_row[i_scan.victim].word  = i_req.fill_data;
        end

        for (int i = 0; i < WAYS; i++) begin
            if ((WAY_W'(i) != i_scan.victim) && (i_row[i].rank > old_rank)) begin
                o_row[i].rank = i_row[i].rank - RANK_W'(1);
            end
        end
        o_row[i_scan.victim].rank = RANK_W'(WAYS - 1);

        if (i_req.kind == KIND_WRITE) begin
            o_row[i_scan.victim].word  = i_req.write_data;
            o_row[i_scan.victim].dirty = 1'b1;
            o_rsp.read_data            = '0;
        end else begin
            o_rsp.read_data = o_row[i_scan.victim].word;
        end

        o_rsp.hit             = i_scan.hit;
        o_rsp.writeback_valid = wb;
        o_rsp.writeback_addr  = wb ? line_addr(old_way.tag, i_set) : '0;
        o_rsp.writeback_data  = wb ? old_way.word : '0;
    end

endmodule

// File: hw/rtl/set_assoc_writeback_lru_cache.sv
// top level: set row memory, per-set written flags and the access sequencer
//
//  channel   | ports               | handshake
//  ----------+---------------------+-----------------------------------------
//  request   | i_req (t_in)        | taken when start is high and busy is low
//  response  | o_rsp (t_out)       | o_done high for one cycle, cannot stall
//
// a transaction: the set row is read at acceptance, the shared compare unit then
// steps through one way per cycle, and a final write state writes the row back
// and registers the response.
// reset clears the per-set written flags at once, so no clearing pass is run.
// busy is high from acceptance until the response strobe; the receiver never stalls.
module set_assoc_writeback_lru_cache import sawlc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_req,
    output logic o_done,
    output t_out o_rsp
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [WAY_W-1:0] r_way, n_way;
    t_in              r_req;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    t_row             r_row;
    logic             r_rowv;
    logic [SETS-1:0]  r_written;
    t_out             r_rsp;
    logic             r_done;

    t_row             mem [SETS];

    logic             accept;
    logic [SET_W-1:0] req_set;
    t_row             eff_row;
    t_row             new_row;
    t_scan            scan_res;
    t_out             upd_rsp;
    logic             wr_en;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign req_set = set_of(i_req.addr);
    assign wr_en   = (r_state == ST_WRITE);
    // a set never written since reset reads as all invalid, clean, rank zero
    assign eff_row = r_rowv ? r_row : '0;

    always_comb begin
        n_state = r_state;
        n_way   = r_way;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                    n_way   = '0;
                end
            end
            ST_SCAN: begin
                if (r_way == WAY_W'(WAYS - 1)) begin
                    n_state = ST_WRITE;
                end else begin
                    n_way = r_way + WAY_W'(1);
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_way     <= '0;
            r_written <= '0;
            r_rowv    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_way   <= n_way;
            r_done  <= wr_en;
            if (accept) begin
                r_rowv <= r_written[req_set];
            end
            if (wr_en) begin
                r_written[r_set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_set <= req_set;
            r_tag <= tag_of(i_req.addr);
        end
        if (wr_en) begin
            r_rsp <= upd_rsp;
        end
    end

    // set row memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_set] <= new_row;
        end
        if (accept) begin
            r_row <= mem[req_set];
        end
    end

    sawlc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (accept),
        .i_step  (r_state == ST_SCAN),
        .i_way   (r_way),
        .i_entry (eff_row[r_way]),
        .i_tag   (r_tag),
        .o_scan  (scan_res)
    );

    sawlc_update u_update (
        .i_row  (eff_row),
        .i_scan (scan_res),
        .i_req  (r_req),
        .i_set  (r_set),
        .i_tag  (r_tag),
        .o_row  (new_row),
        .o_rsp  (upd_rsp)
    );

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_write_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> (o_done && !busy))
        else $error("response strobe missing after row write");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ((r_state == ST_SCAN) && (r_way == '0)))
        else $error("accepted transaction did not start the way scan");

    a_wb_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.hit && o_rsp.writeback_valid))
        else $error("write-back reported on a hit");

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_req.kind == KIND_WRITE)) |-> (o_rsp.read_data == '0))
        else $error("write transaction returned read data");

endmodule

// File: sim/tb.sv
// testbench for the set-associative write-back lru cache with a self-checking line predictor
module tb;
    import sawlc_pkg::*;

    localparam logic KIND_READ   = 1'b0;
    localparam int   ACCESS_CYC  = WAYS + 2;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   HOT_SETS    = 4;
    localparam int   HOT_TAGS    = 6;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_in  req_bus = '0;
    logic o_done;
    t_out rsp_bus;

    // predicted cache contents, one entry per set and way
    logic [TAG_W-1:0]  way_tag   [SETS*WAYS];
    bit                way_valid [SETS*WAYS];
    bit                way_dirty [SETS*WAYS];
    logic [31:0]       way_word  [SETS*WAYS];
    logic [RANK_W-1:0] way_rank  [SETS*WAYS];

    t_out        pending_responses[$];
    t_out        oldest_rsp;
    int          errors      = 0;
    int          cycle_count = 0;
    bit          idle_en     = 1'b1;
    int unsigned hot_set [HOT_SETS];
    int unsigned hot_tag [HOT_TAGS];

    set_assoc_writeback_lru_cache i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (req_bus),
        .o_done (o_done),
        .o_rsp  (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    // computes the response of one access and updates the predicted cache contents
    function automatic t_out cache_access_result(input t_in req);
        logic [31:0]       a;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] old_rank;
        int unsigned       set_idx;
        int unsigned       base;
        int unsigned       victim;
        bit                found;
        bit                free_way;
        t_out              r;
        r        = '0;
        a        = req.addr & ADDR_MASK;
        set_idx  = int'((64'(a) >> (TAG_LEN + 2)) % 64'(SETS));
        tag      = TAG_W'((a >> 2) & TAG_MASK);
        base     = set_idx * WAYS;
        found    = 1'b0;
        free_way = 1'b0;
        victim   = 0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && way_valid[base+w] && way_tag[base+w] == tag) begin
                found  = 1'b1;
                victim = w;
            end
        end
        r.hit = found;
        if (!found) begin
            for (int w = 0; w < WAYS; w++) begin
                if (!free_way && !way_valid[base+w]) begin
                    free_way = 1'b1;
                    victim   = w;
                end
            end
            if (!free_way) begin
                // lowest rank wins, lowest way on a tie
                victim = 0;
                for (int w = 1; w < WAYS; w++) begin
                    if (way_rank[base+w] < way_rank[base+victim]) begin
                        victim = w;
                    end
                end
                if (way_dirty[base+victim]) begin
                    r.writeback_valid = 1'b1;
                    r.writeback_addr  = 32'((64'(way_tag[base+victim]) << 2) |
                                            (64'(set_idx) << (TAG_LEN + 2)));
                    r.writeback_data  = way_word[base+victim];
                end
            end
            way_valid[base+victim] = 1'b1;
            way_dirty[base+victim] = 1'b0;
            way_tag[base+victim]   = tag;
            way_word[base+victim]  = req.fill_data;
        end
        old_rank = way_rank[base+victim];
        for (int w = 0; w < WAYS; w++) begin
            if (w != victim && way_rank[base+w] > old_rank) begin
                way_rank[base+w] = way_rank[base+w] - 1'b1;
            end
        end
        way_rank[base+victim] = RANK_W'(WAYS - 1);
        if (req.kind == KIND_WRITE) begin
            way_word[base+victim]  = req.write_data;
            way_dirty[base+victim] = 1'b1;
        end else begin
            r.read_data = way_word[base+victim];
        end
        return r;
    endfunction

    function automatic logic [31:0] line_byte_addr(input int unsigned set_idx,
                                                   input int unsigned tag,
                                                   input int unsigned low);
        return 32'((64'(set_idx) << (TAG_LEN + 2)) | (64'(tag & TAG_MASK) << 2) |
                   64'(low & 3));
    endfunction

    function automatic t_in make_access(input logic kind, input logic [31:0] addr,
                                        input logic [31:0] wdata, input logic [31:0] fdata);
        t_in r;
        r.kind       = kind;
        r.addr       = addr;
        r.write_data = wdata;
        r.fill_data  = fdata;
        return r;
    endfunction

    // mostly accesses to a few busy sets so that hits and evictions are common
    function automatic t_in random_access();
        logic [31:0] addr;
        if ($urandom_range(0, 99) < 85) begin
            addr = line_byte_addr(hot_set[$urandom_range(0, HOT_SETS-1)],
                                  hot_tag[$urandom_range(0, HOT_TAGS-1)],
                                  $urandom_range(0, 3));
        end else begin
            addr = $urandom;
        end
        return make_access(logic'($urandom_range(0, 1)), addr, $urandom, $urandom);
    endfunction

    task automatic pick_hot_lines();
        for (int i = 0; i < HOT_SETS; i++) begin
            hot_set[i] = $urandom_range(0, SETS-1);
        end
        for (int i = 0; i < HOT_TAGS; i++) begin
            hot_tag[i] = $urandom;
        end
    endtask

    // start stays high between back-to-back transactions
    task automatic send_access(input t_in req);
        if (idle_en && $urandom_range(0, 99) < 23) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start   <= 1'b1;
        req_bus <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_responses.push_back(cache_access_result(req));
    endtask

    task automatic wait_for_responses();
        while (pending_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        int unsigned top;
        top     = SETS - 1;
        idle_en = 1'b0;
        // cold miss, then the same line with the low address bits set
        send_access(make_access(KIND_READ, line_byte_addr(0, 0, 0), 32'h0, 32'h1111_0000));
        send_access(make_access(KIND_READ, line_byte_addr(0, 0, 3), 32'h0, 32'hdead_beef));
        send_access(make_access(KIND_WRITE, line_byte_addr(0, 0, 1), 32'hffff_ffff, 32'h0));
        // write miss allocates, then fill the rest of the set
        send_access(make_access(KIND_WRITE, line_byte_addr(0, 1, 0), 32'h0, 32'hffff_ffff));
        send_access(make_access(KIND_READ, line_byte_addr(0, 2, 2), 32'h0, 32'h2222_2222));
        send_access(make_access(KIND_READ, line_byte_addr(0, 3, 0), 32'h0, 32'h3333_3333));
        // touching way 0 moves the lru choice to the dirty way 1
        send_access(make_access(KIND_READ, line_byte_addr(0, 0, 0), 32'h0, 32'h0));
        send_access(make_access(KIND_READ, line_byte_addr(0, 4, 0), 32'h0, 32'h4444_4444));
        send_access(make_access(KIND_WRITE, line_byte_addr(0, 5, 0), 32'h5555_aaaa, 32'h0));
        send_access(make_access(KIND_READ, line_byte_addr(0, 6, 0), 32'h0, 32'h6666_6666));
        send_access(make_access(KIND_READ, line_byte_addr(0, 7, 0), 32'h0, 32'h7777_7777));
        send_access(make_access(KIND_READ, line_byte_addr(0, 5, 0), 32'h0, 32'h0));
        // top of the address space
        send_access(make_access(KIND_READ, 32'hffff_ffff, 32'h0, 32'hffff_ffff));
        send_access(make_access(KIND_WRITE, 32'hffff_fffc, 32'h0, 32'h0));
        send_access(make_access(KIND_WRITE, line_byte_addr(top, 1, 0), 32'ha5a5_5a5a, 32'h0));
        send_access(make_access(KIND_WRITE, line_byte_addr(top, 2, 3), 32'h0123_4567, 32'h0));
        send_access(make_access(KIND_WRITE, line_byte_addr(top, 3, 0), 32'h89ab_cdef, 32'h0));
        send_access(make_access(KIND_READ, line_byte_addr(top, 4, 0), 32'h0, 32'h0bad_f00d));
        send_access(make_access(KIND_WRITE, line_byte_addr(top, 5, 0), 32'hffff_ffff,
                                32'hffff_ffff));
        send_access(make_access(KIND_READ, line_byte_addr(top, TAG_MASK, 0), 32'h0, 32'h0));
        send_access(make_access(KIND_WRITE, 32'h0000_0000, 32'h0, 32'h0));
        idle_en = 1'b1;
    endtask

    task automatic test_random_traffic(input int count);
        pick_hot_lines();
        idle_en = 1'b1;
        repeat (count) send_access(random_access());
    endtask

    task automatic test_back_to_back(input int count);
        pick_hot_lines();
        idle_en = 1'b0;
        repeat (count) send_access(random_access());
        idle_en = 1'b1;
    endtask

    // short bursts, each followed by a pause until every response is back
    task automatic test_drain_between(input int count);
        int sent;
        sent = 0;
        pick_hot_lines();
        idle_en = 1'b1;
        while (sent < count) begin
            repeat ($urandom_range(1, 10)) begin
                send_access(random_access());
                sent++;
            end
            start <= 1'b0;
            wait_for_responses();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %p", $time, rsp_bus);
                errors++;
            end else begin
                oldest_rsp = pending_responses.pop_front();
                check_field("read_data", oldest_rsp.read_data, rsp_bus.read_data);
                check_field("hit", 32'(oldest_rsp.hit), 32'(rsp_bus.hit));
                check_field("writeback_valid", 32'(oldest_rsp.writeback_valid),
                            32'(rsp_bus.writeback_valid));
                check_field("writeback_addr", oldest_rsp.writeback_addr,
                            rsp_bus.writeback_addr);
                check_field("writeback_data", oldest_rsp.writeback_data,
                            rsp_bus.writeback_data);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SETS*WAYS; i++) begin
            way_valid[i] = 1'b0;
            way_dirty[i] = 1'b0;
            way_rank[i]  = '0;
            way_tag[i]   = '0;
            way_word[i]  = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(300);
        test_back_to_back(150);
        test_drain_between(200);
        test_random_traffic(80);

        start <= 1'b0;
        wait_for_responses();
        repeat (2 * ACCESS_CYC) @(posedge i_clk);
        if (errors == 0 && pending_responses.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
